// ===== rtl/char_lcd_request_sequencer_assert.svh =====
// Assertion macros shared by the character LCD request sequencer RTL
`ifndef CHAR_LCD_REQUEST_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_REQUEST_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CLRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CLRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/clrs_pkg.sv =====
// Types, codes and constants for the character LCD request sequencer
package clrs_pkg;

    localparam int MAX_TEXT_DEFAULT = 32;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] text_length;
        logic [1:0] row;
        logic [5:0] column;
        logic [4:0] char_index;
        logic [7:0] char_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] request_status;
        logic [1:0] lcd_mode;
        logic       busy_res;
        logic       rs_pin;
        logic       rw_pin;
        logic       en_pin;
        logic [7:0] data_pins;
        logic [2:0] done_request;
    } t_out_item;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_INIT   = 3'd1,
        ACT_WRITE  = 3'd2,
        ACT_CURSOR = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_LOAD   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_BUSY     = 2'd1,
        ST_PARAM    = 2'd2,
        ST_NONE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_INIT   = 3'd1,
        K_WRITE  = 3'd2,
        K_CURSOR = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        MODE_OFF  = 3'b001,
        MODE_INIT = 3'b010,
        MODE_OPER = 3'b100
    } t_mode;

    localparam logic [1:0] MODE_CODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_CODE_INIT = 2'd1;
    localparam logic [1:0] MODE_CODE_OPER = 2'd2;

    localparam logic [2:0] STEP_POWER = 3'd0;
    localparam logic [2:0] STEP_LAST  = 3'd4;

    localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] ROW1_OFFSET    = 8'h40;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'd128;

    function automatic logic [7:0] power_on_cmd(input logic [2:0] step);
        logic [7:0] cmd;
        case (step)
            3'd1:    cmd = CMD_FUNC_SET;
            3'd2:    cmd = CMD_DISPLAY_ON;
            3'd3:    cmd = CMD_CLEAR;
            default: cmd = CMD_ENTRY_MODE;
        endcase
        return cmd;
    endfunction

    function automatic logic [1:0] mode_code(input t_mode mode);
        logic [1:0] code;
        unique case (mode)
            MODE_INIT: code = MODE_CODE_INIT;
            MODE_OPER: code = MODE_CODE_OPER;
            default:   code = MODE_CODE_OFF;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/char_lcd_request_sequencer.sv =====
// Character LCD request sequencer: request decode, tick sequencing and text buffer
//
// Drives an 8-bit HD44780-style character LCD (RS, RW, EN, D0-D7), one tick item
// at a time. Init, write text, set cursor and clear requests are taken when not
// busy and run on later ticks; each command or character byte takes two ticks
// (EN high, then EN low). Load items fill the text buffer, which is held in
// flip-flops. Every item gives one result item. The block takes one item per
// clock cycle when the output is not stalled: an input register feeds the
// combinational state update and decode, whose outcome lands in the output register.
// Each item's state update is registered before the next item is decoded; a stalled
// output holds the input register and stalls the input side.
module char_lcd_request_sequencer #(
    parameter int MAX_TEXT = clrs_pkg::MAX_TEXT_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  clrs_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output clrs_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import clrs_pkg::*;
    `include "char_lcd_request_sequencer_assert.svh"

    localparam int BUF_DEPTH = (MAX_TEXT < 32) ? MAX_TEXT : 32;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;
    logic       advance;

    t_mode      r_mode,  n_mode;
    logic [2:0] r_step,  n_step;
    logic       r_busy,  n_busy;
    t_kind      r_kind,  n_kind;
    logic [5:0] r_len,   n_len;
    logic       r_row,   n_row;
    logic [5:0] r_col,   n_col;
    logic [5:0] r_pos,   n_pos;
    logic       r_en,    n_en;
    logic       r_sel,   n_sel;
    logic [7:0] r_data,  n_data;

    logic [7:0] r_buf [BUF_DEPTH];
    logic [7:0] buf_rd;
    logic       buf_we;
    logic [7:0] cursor_addr;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign buf_rd = (r_pos < BUF_DEPTH) ? r_buf[r_pos[BUF_AW-1:0]] : 8'd0;
    assign buf_we = advance && (t_action'(r_in_item.action) == ACT_LOAD)
                    && (r_in_item.char_index < BUF_DEPTH);
    assign cursor_addr = r_row ? (ROW1_OFFSET + {2'b00, r_col}) : {2'b00, r_col};

    always_comb begin
        t_status status;
        t_kind   done;
        status = ST_NONE;
        done   = K_NONE;
        n_mode = r_mode;
        n_step = r_step;
        n_busy = r_busy;
        n_kind = r_kind;
        n_len  = r_len;
        n_row  = r_row;
        n_col  = r_col;
        n_pos  = r_pos;
        n_en   = r_en;
        n_sel  = r_sel;
        n_data = r_data;

        unique case (t_action'(r_in_item.action))
            ACT_TICK: begin
                unique case (r_mode)
                    MODE_OFF: begin
                        if (r_kind == K_INIT) begin
                            n_mode = MODE_INIT;
                        end
                    end
                    MODE_INIT: begin
                        if (r_step == STEP_POWER) begin
                            n_step = 3'd1;
                        end else if (r_step <= STEP_LAST) begin
                            n_sel  = 1'b0;
                            n_data = power_on_cmd(r_step);
                            n_en   = ~r_en;
                            if (r_en) begin
                                n_step = r_step + 3'd1;
                                if (r_step == STEP_LAST) begin
                                    n_busy = 1'b0;
                                    done   = K_INIT;
                                    n_mode = MODE_OPER;
                                end
                            end
                        end else begin
                            n_mode = MODE_OPER;
                        end
                    end
                    MODE_OPER: begin
                        if (r_busy) begin
                            case (r_kind)
                                K_WRITE: begin
                                    if (r_pos < r_len) begin
                                        n_sel  = 1'b1;
                                        n_data = buf_rd;
                                        n_en   = ~r_en;
                                        if (r_en) begin
                                            n_pos = r_pos + 6'd1;
                                        end
                                    end else begin
                                        n_sel  = 1'b1;
                                        n_pos  = 6'd0;
                                        n_busy = 1'b0;
                                        done   = K_WRITE;
                                    end
                                end
                                K_CURSOR: begin
                                    n_sel  = 1'b0;
                                    n_data = CMD_SET_DDRAM + cursor_addr;
                                    n_en   = ~r_en;
                                    if (r_en) begin
                                        n_busy = 1'b0;
                                        done   = K_CURSOR;
                                    end
                                end
                                K_CLEAR: begin
                                    n_sel  = 1'b0;
                                    n_data = CMD_CLEAR;
                                    n_en   = ~r_en;
                                    if (r_en) begin
                                        n_busy = 1'b0;
                                        done   = K_CLEAR;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            ACT_INIT: begin
                if (r_busy) begin
                    status = ST_BUSY;
                end else begin
                    status = ST_ACCEPTED;
                    n_busy = 1'b1;
                    n_kind = K_INIT;
                end
            end
            ACT_WRITE: begin
                if (r_busy) begin
                    status = ST_BUSY;
                end else begin
                    status = ST_ACCEPTED;
                    n_busy = 1'b1;
                    n_kind = K_WRITE;
                    n_len  = r_in_item.text_length;
                    n_pos  = 6'd0;
                end
            end
            ACT_CURSOR: begin
                if (r_in_item.row > 2'd1) begin
                    status = ST_PARAM;
                end else if (r_busy) begin
                    status = ST_BUSY;
                end else begin
                    status = ST_ACCEPTED;
                    n_busy = 1'b1;
                    n_kind = K_CURSOR;
                    n_row  = r_in_item.row[0];
                    n_col  = r_in_item.column;
                end
            end
            ACT_CLEAR: begin
                if (r_busy) begin
                    status = ST_BUSY;
                end else begin
                    status = ST_ACCEPTED;
                    n_busy = 1'b1;
                    n_kind = K_CLEAR;
                end
            end
            default: ;
        endcase

        n_out_item.request_status = status;
        n_out_item.lcd_mode       = mode_code(n_mode);
        n_out_item.busy_res       = n_busy;
        n_out_item.rs_pin         = n_sel;
        n_out_item.rw_pin         = 1'b0;
        n_out_item.en_pin         = n_en;
        n_out_item.data_pins      = n_data;
        n_out_item.done_request   = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_OFF;
            r_step      <= STEP_POWER;
            r_busy      <= 1'b0;
            r_kind      <= K_NONE;
            r_len       <= 6'd0;
            r_row       <= 1'b0;
            r_col       <= 6'd0;
            r_pos       <= 6'd0;
            r_en        <= 1'b0;
            r_sel       <= 1'b0;
            r_data      <= 8'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_step      <= n_step;
                r_busy      <= n_busy;
                r_kind      <= n_kind;
                r_len       <= n_len;
                r_row       <= n_row;
                r_col       <= n_col;
                r_pos       <= n_pos;
                r_en        <= n_en;
                r_sel       <= n_sel;
                r_data      <= n_data;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[r_in_item.char_index[BUF_AW-1:0]] <= r_in_item.char_value;
        end
    end

    `CLRS_ASSERT_IMP(a_done_clears_busy, i_clk, i_rst_n,
        o_out_valid && (o_out_item.done_request != K_NONE), !o_out_item.busy_res,
        "finished request still reports busy")
    `CLRS_ASSERT_IMP(a_done_en_low, i_clk, i_rst_n,
        o_out_valid && (o_out_item.done_request != K_NONE), !o_out_item.en_pin,
        "request finished with EN high")
    `CLRS_ASSERT_IMP(a_done_on_tick_only, i_clk, i_rst_n,
        o_out_valid && (o_out_item.done_request != K_NONE),
        o_out_item.request_status == ST_NONE,
        "done reported on a request item")
    `CLRS_ASSERT_NXT(a_advance_gives_result, i_clk, i_rst_n,
        advance, r_out_valid,
        "processed item produced no result")

endmodule

// ===== tb/sv/char_lcd_request_sequencer_tb.sv =====
// Self-checking testbench for the character LCD request sequencer: item predictor, driver and monitor
`timescale 1ns / 100ps

module char_lcd_request_sequencer_tb;
    import clrs_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam logic [2:0] STEP_FIRST  = STEP_POWER + 3'd1;
    localparam logic [2:0] STEP_DONE   = STEP_LAST + 3'd1;
    localparam logic [1:0] ROW_LAST    = 2'd1;
    localparam int ITEM_TARGET = 1640;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_LEN    = 300;
    localparam int MAX_PRINT   = 30;
    localparam int CYCLE_LIMIT = 1000000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    char_lcd_request_sequencer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // predictor state, zero at reset
    logic [1:0] lcd_mode_q = MODE_CODE_OFF;
    logic [2:0] pwr_step   = STEP_POWER;
    logic       seq_busy   = 1'b0;
    t_kind      job_kind   = K_NONE;
    logic [5:0] job_len    = '0;
    logic       job_row    = 1'b0;
    logic [5:0] job_col    = '0;
    logic [5:0] text_pos   = '0;
    logic       en_lvl     = 1'b0;
    logic       rs_lvl     = 1'b0;
    logic [7:0] db_lvl     = '0;
    logic [7:0] text_mem [MAX_TEXT_DEFAULT] = '{default: '0};

    t_in_item  items_to_send [$];
    t_out_item lcd_results_due [$];
    bit        slot_written [MAX_TEXT_DEFAULT];

    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_cycles    = 0;
    bit hold_used      = 1'b0;
    int n_taken        = 0;
    int n_refused      = 0;
    int n_row_err      = 0;
    int done_seen [5]  = '{default: 0};

    task automatic drive_byte(input logic rs, input logic [7:0] b, output bit fell);
        rs_lvl = rs;
        db_lvl = b;
        en_lvl = ~en_lvl;
        fell   = (en_lvl == 1'b0);
    endtask

    task automatic claim(input t_kind k, output t_status st);
        if (seq_busy) begin
            st = ST_BUSY;
        end else begin
            seq_busy = 1'b1;
            job_kind = k;
            st       = ST_ACCEPTED;
        end
    endtask

    task automatic lcd_step(input t_in_item it, output t_out_item res);
        t_status    st;
        t_kind      fin;
        bit         fell;
        logic [7:0] b;
        st  = ST_NONE;
        fin = K_NONE;
        case (it.action)
            ACT_TICK: begin
                if (lcd_mode_q == MODE_CODE_OFF) begin
                    if (job_kind == K_INIT) lcd_mode_q = MODE_CODE_INIT;
                end else if (lcd_mode_q == MODE_CODE_INIT) begin
                    if (pwr_step == STEP_POWER) begin
                        pwr_step = STEP_FIRST;
                    end else if (pwr_step <= STEP_LAST) begin
                        case (pwr_step)
                            3'd1:    b = CMD_FUNC_SET;
                            3'd2:    b = CMD_DISPLAY_ON;
                            3'd3:    b = CMD_CLEAR;
                            default: b = CMD_ENTRY_MODE;
                        endcase
                        drive_byte(1'b0, b, fell);
                        if (fell) begin
                            pwr_step = pwr_step + 3'd1;
                            if (pwr_step == STEP_DONE) begin
                                seq_busy   = 1'b0;
                                fin        = K_INIT;
                                lcd_mode_q = MODE_CODE_OPER;
                            end
                        end
                    end else begin
                        lcd_mode_q = MODE_CODE_OPER;
                    end
                end else if (seq_busy) begin
                    case (job_kind)
                        K_WRITE: begin
                            if (text_pos < job_len) begin
                                b = (text_pos < MAX_TEXT_DEFAULT) ?
                                    text_mem[text_pos[4:0]] : 8'h00;
                                drive_byte(1'b1, b, fell);
                                if (fell) text_pos = text_pos + 6'd1;
                            end else begin
                                rs_lvl   = 1'b1;
                                text_pos = '0;
                                seq_busy = 1'b0;
                                fin      = K_WRITE;
                            end
                        end
                        K_CURSOR: begin
                            b = CMD_SET_DDRAM + (job_row ? ROW1_OFFSET : 8'h00)
                                + {2'b00, job_col};
                            drive_byte(1'b0, b, fell);
                            if (fell) begin
                                seq_busy = 1'b0;
                                fin      = K_CURSOR;
                            end
                        end
                        K_CLEAR: begin
                            drive_byte(1'b0, CMD_CLEAR, fell);
                            if (fell) begin
                                seq_busy = 1'b0;
                                fin      = K_CLEAR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ACT_INIT:  claim(K_INIT, st);
            ACT_WRITE: begin
                claim(K_WRITE, st);
                if (st == ST_ACCEPTED) begin
                    job_len  = it.text_length;
                    text_pos = '0;
                end
            end
            ACT_CURSOR: begin
                if (it.row > ROW_LAST) begin
                    st = ST_PARAM;
                end else begin
                    claim(K_CURSOR, st);
                    if (st == ST_ACCEPTED) begin
                        job_row = it.row[0];
                        job_col = it.column;
                    end
                end
            end
            ACT_CLEAR: claim(K_CLEAR, st);
            ACT_LOAD:  text_mem[it.char_index] = it.char_value;
            default: ;
        endcase

        case (st)
            ST_ACCEPTED: n_taken++;
            ST_BUSY:     n_refused++;
            ST_PARAM:    n_row_err++;
            default: ;
        endcase
        if (fin != K_NONE) done_seen[fin]++;

        res.request_status = st;
        res.lcd_mode       = lcd_mode_q;
        res.busy_res       = seq_busy;
        res.rs_pin         = rs_lvl;
        res.rw_pin         = 1'b0;
        res.en_pin         = en_lvl;
        res.data_pins      = db_lvl;
        res.done_request   = fin;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINT)
            $display("%0t result %0d: %s got %0h expected %0h", $realtime, results_seen,
                     what, got, want);
        mismatch_count++;
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic t_in_item rand_item(input logic [2:0] act);
        logic [31:0] bits;
        t_in_item    it;
        bits      = $urandom;
        it        = bits[$bits(t_in_item)-1:0];
        it.action = act;
        return it;
    endfunction

    task automatic add(input t_in_item it);
        items_to_send.push_back(it);
        if (it.action == ACT_LOAD) slot_written[it.char_index] = 1'b1;
    endtask

    // well-formed requests are only offered as noise while the block is known to be busy
    task automatic add_noise(input bit while_busy);
        t_in_item it;
        case ($urandom_range(while_busy ? 5 : 3))
            1: begin
                it     = rand_item(ACT_CURSOR);
                it.row = $urandom_range(1) ? 2'd3 : 2'd2;
            end
            2: it = rand_item($urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B);
            4, 5: begin
                case ($urandom_range(3))
                    0:       it = rand_item(ACT_INIT);
                    1:       it = rand_item(ACT_WRITE);
                    2:       it = rand_item(ACT_CURSOR);
                    default: it = rand_item(ACT_CLEAR);
                endcase
            end
            default: it = rand_item(ACT_LOAD);
        endcase
        add(it);
    endtask

    task automatic add_request(input t_in_item req, input int ticks);
        add(req);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(99) < 20) add_noise(1'b1);
            add(rand_item(ACT_TICK));
        end
        repeat ($urandom_range(2)) begin
            if ($urandom_range(99) < 30) add_noise(1'b0);
            add(rand_item(ACT_TICK));
        end
    endtask

    // driver
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                lcd_step(in_item, want);
                lcd_results_due.push_back(want);
            end
            if (!(in_valid && o_in_stall)) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (items_to_send.size() != 0) begin
                    in_valid <= 1'b1;
                    in_item  <= items_to_send.pop_front();
                    gap_left <= ((items_sent / 150) % 4 == 3) ? 0 : idle_len();
                    items_sent++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and output stall
    always @(posedge clk) begin
        t_out_item want;
        int        n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (lcd_results_due.size() == 0) begin
                    flag_mismatch("unexpected item", 32'(o_out_item), 32'd0);
                end else begin
                    want = lcd_results_due.pop_front();
                    if (o_out_item.request_status !== want.request_status)
                        flag_mismatch("request_status", 32'(o_out_item.request_status),
                                      32'(want.request_status));
                    if (o_out_item.lcd_mode !== want.lcd_mode)
                        flag_mismatch("lcd_mode", 32'(o_out_item.lcd_mode),
                                      32'(want.lcd_mode));
                    if (o_out_item.busy_res !== want.busy_res)
                        flag_mismatch("busy_res", 32'(o_out_item.busy_res),
                                      32'(want.busy_res));
                    if (o_out_item.rs_pin !== want.rs_pin)
                        flag_mismatch("rs_pin", 32'(o_out_item.rs_pin), 32'(want.rs_pin));
                    if (o_out_item.rw_pin !== want.rw_pin)
                        flag_mismatch("rw_pin", 32'(o_out_item.rw_pin), 32'(want.rw_pin));
                    if (o_out_item.en_pin !== want.en_pin)
                        flag_mismatch("en_pin", 32'(o_out_item.en_pin), 32'(want.en_pin));
                    if (o_out_item.data_pins !== want.data_pins)
                        flag_mismatch("data_pins", 32'(o_out_item.data_pins),
                                      32'(want.data_pins));
                    if (o_out_item.done_request !== want.done_request)
                        flag_mismatch("done_request", 32'(o_out_item.done_request),
                                      32'(want.done_request));
                end
                results_seen <= results_seen + 1;
            end
            if (hold_cycles != 0) begin
                out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                n          = ((results_seen / 170) % 4 == 1) ? 0 : idle_len();
                out_stall  <= (n != 0);
                stall_left <= (n != 0) ? n - 1 : 0;
            end
        end
    end

    // one long output hold so the block backs up and stalls its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_cycles <= 0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_used && results_seen >= HOLD_AT) begin
            hold_cycles <= HOLD_LEN;
            hold_used   <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d items still due", cycle_count,
                     lcd_results_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        int       r;
        int       p;

        // directed: off state, field extremes, power-on, every request kind
        add(rand_item(ACT_TICK));
        it = rand_item(ACT_CURSOR);
        it.row    = 2'd3;
        it.column = 6'd63;
        add(it);
        add(rand_item(ACT_SPARE_B));
        it = rand_item(ACT_LOAD);
        it.char_index = 5'd0;
        it.char_value = 8'hFF;
        add(it);
        it = rand_item(ACT_LOAD);
        it.char_index = 5'd1;
        it.char_value = 8'h00;
        add(it);
        it = rand_item(ACT_LOAD);
        it.char_index = 5'd31;
        it.char_value = 8'h5A;
        add(it);
        add(rand_item(ACT_INIT));
        add(rand_item(ACT_CLEAR));
        repeat (10) add(rand_item(ACT_TICK));
        it = rand_item(ACT_WRITE);
        it.text_length = 6'd2;
        add_request(it, 5);
        it = rand_item(ACT_WRITE);
        it.text_length = 6'd0;
        add_request(it, 1);
        it = rand_item(ACT_CURSOR);
        it.row    = 2'd1;
        it.column = 6'd63;
        add_request(it, 2);
        add_request(rand_item(ACT_CLEAR), 2);

        // random well-formed request sequences with noise in between
        while (items_to_send.size() < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 40) begin
                it = rand_item(ACT_WRITE);
                p  = $urandom_range(99);
                it.text_length = (p < 85) ? 6'($urandom_range(6)) :
                                 (p < 97) ? 6'($urandom_range(32, 7)) :
                                            6'($urandom_range(63, 33));
                // never let a write read a slot that holds nothing yet
                for (int s = 0; s < it.text_length && s < MAX_TEXT_DEFAULT; s++) begin
                    if (!slot_written[s]) begin
                        t_in_item ld;
                        ld = rand_item(ACT_LOAD);
                        ld.char_index = 5'(s);
                        add(ld);
                    end
                end
                add_request(it, 2 * it.text_length + 1);
            end else if (r < 65) begin
                it = rand_item(ACT_CURSOR);
                it.row = 2'($urandom_range(1));
                add_request(it, 2);
            end else if (r < 85) begin
                add_request(rand_item(ACT_CLEAR), 2);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    if ($urandom_range(1)) add_noise(1'b0);
                    else add(rand_item(ACT_TICK));
                end
            end
        end

        // init while operating is never served: busy stays set from here on
        add(rand_item(ACT_INIT));
        repeat (4) add(rand_item(ACT_TICK));
        add(rand_item(ACT_CLEAR));
        add(rand_item(ACT_TICK));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (items_to_send.size() != 0 || in_valid) @(posedge clk);
        while (lcd_results_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d items: %0d requests taken, %0d refused busy, %0d bad rows",
                 items_sent, n_taken, n_refused, n_row_err);
        $display("Completed %0d init, %0d write, %0d cursor, %0d clear; %s %0d cycles once",
                 done_seen[K_INIT], done_seen[K_WRITE], done_seen[K_CURSOR],
                 done_seen[K_CLEAR], "output held", HOLD_LEN);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
